/* src/bcle_pkg.sv */
`default_nettype none
package bcle_pkg;

   localparam logic [2:0] OP_DELETE_FIRST   = 3'd0;
   localparam logic [2:0] OP_DELETE_ALL     = 3'd1;
   localparam logic [2:0] OP_FIND           = 3'd2;
   localparam logic [2:0] OP_INSERT_UNIQUE  = 3'd3;
   localparam logic [2:0] OP_INSERT_SORTED  = 3'd4;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_PRESENT    = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   typedef struct packed {
      logic [2:0]        op;
      logic signed [7:0] value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [1:0] status;
      logic [4:0] removed;
      logic [4:0] length;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } state_type;

endpackage
`default_nettype wire

/* src/bcle_ram.sv */
`default_nettype none
module bcle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

/* src/bcle_controller.sv */
`default_nettype none
module bcle_controller (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         scan_done,
   output logic              busy,
   output bcle_pkg::cmd_type cmd
);

   bcle_pkg::state_type state_ff;
   bcle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcle_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcle_pkg::FSM_IDLE: begin
            if (start) begin
               state_in = bcle_pkg::FSM_SCAN;
            end
         end
         bcle_pkg::FSM_SCAN: begin
            if (scan_done) begin
               state_in = bcle_pkg::FSM_FINISH;
            end
         end
         bcle_pkg::FSM_FINISH: begin
            state_in = bcle_pkg::FSM_IDLE;
         end
         default: begin
            state_in = bcle_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         bcle_pkg::FSM_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         bcle_pkg::FSM_SCAN: begin
            cmd.issue = 1'b1;
         end
         bcle_pkg::FSM_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/bcle_datapath.sv */
`default_nettype none
module bcle_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcle_pkg::cmd_type cmd,
   input  wire bcle_pkg::req_type req,
   output logic                   scan_done,
   output logic                   rsp_strobe,
   output bcle_pkg::rsp_type      rsp
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]     used_ff, used_in;
   logic [2:0]        op_ff, op_in;
   logic signed [7:0] value_ff, value_in;
   logic [CW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic              data_valid_ff, data_valid_in;
   logic [CW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]     removed_ff, removed_in;
   logic              found_ff, found_in;
   logic              ins_done_ff, ins_done_in;
   logic [7:0]        carry_ff, carry_in;
   logic              full_ff, full_in;
   bcle_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic          more;
   logic          rd_en;
   logic          match;
   logic          drop;
   logic          we;
   logic [IW-1:0] waddr;
   logic [7:0]    wdata;
   logic [7:0]    rd_data;
   logic [1:0]    status;

   bcle_ram #(
      .WIDTH(8),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (rd_en),
      .raddr(rd_ptr_ff[IW-1:0]),
      .rdata(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         data_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         data_valid_ff <= data_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      rd_ptr_ff   <= rd_ptr_in;
      pos_ff      <= pos_in;
      wr_ptr_ff   <= wr_ptr_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      ins_done_ff <= ins_done_in;
      carry_ff    <= carry_in;
      full_ff     <= full_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      more      = rd_ptr_ff < used_ff;
      rd_en     = cmd.issue && more;
      scan_done = !more && !data_valid_ff;
      match     = data_valid_ff && (rd_data == value_ff);
      drop      = 1'b0;
      status    = bcle_pkg::STATUS_DONE;

      used_in       = used_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      rd_ptr_in     = rd_ptr_ff;
      pos_in        = pos_ff;
      data_valid_in = rd_en;
      wr_ptr_in     = wr_ptr_ff;
      removed_in    = removed_ff;
      found_in      = found_ff;
      ins_done_in   = ins_done_ff;
      carry_in      = carry_ff;
      full_in       = full_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = cmd.finish;

      we    = 1'b0;
      waddr = wr_ptr_ff[IW-1:0];
      wdata = rd_data;

      if (cmd.load) begin
         op_in       = req.op;
         value_in    = req.value;
         rd_ptr_in   = '0;
         wr_ptr_in   = '0;
         removed_in  = '0;
         found_in    = 1'b0;
         ins_done_in = 1'b0;
         full_in     = (used_ff == CW'(CAPACITY));
      end

      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         pos_in    = rd_ptr_ff[IW-1:0];
      end

      // one stored entry per cycle: flag a match, compact for deletes, ripple for sorted insert
      if (data_valid_ff) begin
         if (match) begin
            found_in = 1'b1;
         end
         case (op_ff)
            bcle_pkg::OP_DELETE_FIRST, bcle_pkg::OP_DELETE_ALL: begin
               drop = match && ((op_ff == bcle_pkg::OP_DELETE_ALL) || (removed_ff == '0));
               if (drop) begin
                  removed_in = removed_ff + 1'b1;
               end else begin
                  we        = 1'b1;
                  waddr     = wr_ptr_ff[IW-1:0];
                  wdata     = rd_data;
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end
            bcle_pkg::OP_INSERT_SORTED: begin
               if (!full_ff) begin
                  if (ins_done_ff) begin
                     we       = 1'b1;
                     waddr    = pos_ff;
                     wdata    = carry_ff;
                     carry_in = rd_data;
                  end else if ($signed(rd_data) >= value_ff) begin
                     we          = 1'b1;
                     waddr       = pos_ff;
                     wdata       = value_ff;
                     carry_in    = rd_data;
                     ins_done_in = 1'b1;
                  end
               end
            end
            default: begin
               drop = 1'b0;
            end
         endcase
      end

      if (cmd.finish) begin
         status = found_ff ? bcle_pkg::STATUS_DONE : bcle_pkg::STATUS_NOT_FOUND;
         case (op_ff)
            bcle_pkg::OP_DELETE_FIRST, bcle_pkg::OP_DELETE_ALL: begin
               used_in = used_ff - removed_ff;
            end
            bcle_pkg::OP_INSERT_UNIQUE: begin
               if (found_ff) begin
                  status = bcle_pkg::STATUS_PRESENT;
               end else if (full_ff) begin
                  status = bcle_pkg::STATUS_FULL;
               end else begin
                  status  = bcle_pkg::STATUS_DONE;
                  we      = 1'b1;
                  waddr   = used_ff[IW-1:0];
                  wdata   = value_ff;
                  used_in = used_ff + 1'b1;
               end
            end
            bcle_pkg::OP_INSERT_SORTED: begin
               if (full_ff) begin
                  status = bcle_pkg::STATUS_FULL;
               end else begin
                  // the displaced last entry, or the value itself, lands at the tail
                  status  = bcle_pkg::STATUS_DONE;
                  we      = 1'b1;
                  waddr   = used_ff[IW-1:0];
                  wdata   = ins_done_ff ? carry_ff : value_ff;
                  used_in = used_ff + 1'b1;
               end
            end
            default: begin
               used_in = used_ff;
            end
         endcase
         rsp_in.found   = found_ff;
         rsp_in.status  = status;
         rsp_in.removed = 5'(removed_ff);
         rsp_in.length  = 5'(used_in);
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule
`default_nettype wire

/* src/bounded_char_list_engine.sv */
`default_nettype none
// start loads the request, then the scan visits each of the L entries held
// at the start; the scan reads one stored entry per cycle through the single ram read port
// busy falls in the cycle the result is shown, so a new request can start then;
// a new request is taken only once busy has fallen, not during a scan
// rsp_strobe is high for one cycle and the receiver cannot stall it
// synchronous reset empties the list; stored entries are not cleared
module bounded_char_list_engine #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bcle_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output bcle_pkg::rsp_type      rsp_data
);

   bcle_pkg::cmd_type cmd;
   logic              scan_done;

   bcle_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .scan_done(scan_done),
      .busy     (busy),
      .cmd      (cmd)
   );

   bcle_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .scan_done (scan_done),
      .rsp_strobe(rsp_strobe),
      .rsp       (rsp_data)
   );

endmodule
`default_nettype wire

/* tb/tb_bounded_char_list_engine.sv */
`timescale 1ns / 100ps

module tb_bounded_char_list_engine;

   localparam int LIST_DEPTH = 16;
   localparam int ITEM_TOTAL = 1600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST = 3'd7;

   class list_scoreboard;
      byte held[$];
      bcle_pkg::rsp_type awaited[$];
      int mismatches;

      // updates the list copy and works out the reply for one transfer
      function bcle_pkg::rsp_type apply_request(bcle_pkg::req_type r);
         bcle_pkg::rsp_type exp;
         byte v;
         int pos;
         int hits;
         v = r.value;
         hits = 0;
         exp.found = 1'b0;
         foreach (held[i])
            if (held[i] == v) exp.found = 1'b1;
         exp.status = exp.found ? bcle_pkg::STATUS_DONE : bcle_pkg::STATUS_NOT_FOUND;
         exp.removed = '0;
         case (r.op)
            bcle_pkg::OP_DELETE_FIRST: begin
               if (exp.found) begin
                  pos = 0;
                  while (held[pos] != v) pos++;
                  held.delete(pos);
                  exp.removed = 5'd1;
               end
            end
            bcle_pkg::OP_DELETE_ALL: begin
               for (int i = held.size() - 1; i >= 0; i--)
                  if (held[i] == v) begin
                     held.delete(i);
                     hits++;
                  end
               exp.removed = 5'(hits);
            end
            bcle_pkg::OP_INSERT_UNIQUE: begin
               if (exp.found) exp.status = bcle_pkg::STATUS_PRESENT;
               else if (held.size() >= LIST_DEPTH) exp.status = bcle_pkg::STATUS_FULL;
               else begin
                  held.push_back(v);
                  exp.status = bcle_pkg::STATUS_DONE;
               end
            end
            bcle_pkg::OP_INSERT_SORTED: begin
               if (held.size() >= LIST_DEPTH) exp.status = bcle_pkg::STATUS_FULL;
               else begin
                  pos = 0;
                  while (pos < held.size() && held[pos] < v) pos++;
                  held.insert(pos, v);
                  exp.status = bcle_pkg::STATUS_DONE;
               end
            end
            default: ;
         endcase
         exp.length = 5'(held.size());
         return exp;
      endfunction

      function void note_request(bcle_pkg::req_type r);
         awaited.push_back(apply_request(r));
      endfunction

      function void check_reply(bcle_pkg::rsp_type got);
         bcle_pkg::rsp_type exp;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: found=%0d status=%0d removed=%0d length=%0d",
                        got.found, got.status, got.removed, got.length);
         end else begin
            exp = awaited.pop_front();
            if (got.found !== exp.found || got.status !== exp.status ||
                got.removed !== exp.removed || got.length !== exp.length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply mismatch: exp found=%0d status=%0d removed=%0d length=%0d,",
                           exp.found, exp.status, exp.removed, exp.length,
                           " got found=%0d status=%0d removed=%0d length=%0d",
                           got.found, got.status, got.removed, got.length);
            end
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   bcle_pkg::req_type req_data;
   logic              rsp_strobe;
   bcle_pkg::rsp_type rsp_data;

   list_scoreboard sb = new;
   int  cycle_count = 0;
   int  burst_left = 0;
   byte pool[6];
   bit  shrinking = 1'b0;

   bounded_char_list_engine #(
      .CAPACITY(LIST_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** bounded_char_list_engine: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_reply(rsp_data);
   end

   // holds start until the transfer happens, then records it
   task send_request(input logic [2:0] op, input byte value);
      bcle_pkg::req_type r;
      r.op = op;
      r.value = value;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
   endtask

   // bursts of back-to-back requests with idle gaps between them
   task pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            start <= 1'b0;
            req_data.op <= 3'($urandom);
            req_data.value <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task issue(input logic [2:0] op, input byte value);
      send_request(op, value);
      pace();
   endtask

   task wait_for_replies();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function byte pick_value();
      if ($urandom_range(0, 4) == 0) return byte'($urandom);
      return pool[$urandom_range(0, 5)];
   endfunction

   function logic [2:0] pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return OP_UNDEF_FIRST + 3'($urandom_range(0, 2));
      if (!shrinking) begin
         if (roll < 40) return bcle_pkg::OP_INSERT_SORTED;
         if (roll < 75) return bcle_pkg::OP_INSERT_UNIQUE;
         if (roll < 85) return bcle_pkg::OP_FIND;
         if (roll < 95) return bcle_pkg::OP_DELETE_FIRST;
         return bcle_pkg::OP_DELETE_ALL;
      end
      if (roll < 40) return bcle_pkg::OP_DELETE_FIRST;
      if (roll < 65) return bcle_pkg::OP_DELETE_ALL;
      if (roll < 80) return bcle_pkg::OP_FIND;
      if (roll < 90) return bcle_pkg::OP_INSERT_SORTED;
      return bcle_pkg::OP_INSERT_UNIQUE;
   endfunction

   initial begin
      int sent;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, undefined codes, extremes and duplicates
      issue(bcle_pkg::OP_FIND, -8'sd1);
      issue(OP_UNDEF_LAST, 8'sd0);
      issue(bcle_pkg::OP_DELETE_FIRST, 8'sd3);
      issue(bcle_pkg::OP_DELETE_ALL, 8'sd3);
      issue(bcle_pkg::OP_INSERT_SORTED, 8'sd127);
      issue(bcle_pkg::OP_INSERT_SORTED, -8'sd128);
      issue(bcle_pkg::OP_INSERT_SORTED, 8'sd0);
      issue(bcle_pkg::OP_INSERT_SORTED, 8'sd0);
      issue(bcle_pkg::OP_INSERT_UNIQUE, 8'sd0);
      issue(bcle_pkg::OP_INSERT_UNIQUE, 8'sd5);
      issue(OP_UNDEF_FIRST, 8'sd5);
      issue(bcle_pkg::OP_DELETE_ALL, 8'sd0);
      issue(bcle_pkg::OP_DELETE_FIRST, -8'sd128);
      // fill to capacity, then both inserts against a full list
      while (sb.held.size() < LIST_DEPTH) issue(bcle_pkg::OP_INSERT_SORTED, -8'sd1);
      issue(bcle_pkg::OP_INSERT_SORTED, 8'sd1);
      issue(bcle_pkg::OP_INSERT_UNIQUE, 8'sd100);
      issue(bcle_pkg::OP_INSERT_UNIQUE, -8'sd1);
      issue(bcle_pkg::OP_DELETE_FIRST, -8'sd1);
      issue(bcle_pkg::OP_DELETE_ALL, -8'sd1);
      issue(bcle_pkg::OP_DELETE_ALL, 8'sd127);
      issue(bcle_pkg::OP_DELETE_FIRST, 8'sd5);
      wait_for_replies();

      sent = 0;
      while (sent < ITEM_TOTAL) begin
         if (sent % 120 == 0) begin
            foreach (pool[i]) pool[i] = byte'($urandom);
            pool[0] = $urandom_range(0, 1) ? -8'sd128 : 8'sd127;
         end
         if (sb.held.size() >= LIST_DEPTH && $urandom_range(0, 3) == 0) shrinking = 1'b1;
         else if (sb.held.size() <= 1) shrinking = 1'b0;
         if (sent == 500 || sent == 1200) wait_for_replies();
         issue(pick_op(), pick_value());
         sent++;
      end

      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("** bounded_char_list_engine: PASSED **");
      end else begin
         $display("** bounded_char_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
